[rtl/core/mjs_pkg.sv]
// Shared types, codes and record helpers for the multicore job scheduler.
package mjs_pkg;

    localparam int CORES_DEF       = 16;
    localparam int QUEUE_DEPTH_DEF = 32;

    localparam logic [1:0] CMD_NEW = 2'd0;
    localparam logic [1:0] CMD_FIN = 2'd1;
    localparam logic [1:0] CMD_EXP = 2'd2;

    localparam logic [2:0] SCH_FCFS = 3'd0;
    localparam logic [2:0] SCH_SJF  = 3'd1;
    localparam logic [2:0] SCH_PSJF = 3'd2;
    localparam logic [2:0] SCH_PRI  = 3'd3;
    localparam logic [2:0] SCH_PPRI = 3'd4;
    localparam logic [2:0] SCH_RR   = 3'd5;

    localparam logic CFG_SCHEME = 1'b0;
    localparam logic CFG_CORES  = 1'b1;

    localparam logic [2:0] SCHEME_RST = SCH_FCFS;
    localparam logic [4:0] ACTIVE_RST = 5'd4;

    localparam logic signed [16:0] SEL_NONE = -17'sd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] job_id;
        logic [30:0] now;
        logic [15:0] run_length;
        logic [7:0]  job_priority;
        logic [3:0]  core_index;
    } t_in_word;

    typedef struct packed {
        logic signed [16:0] selection;
        logic               queue_overflow;
        logic [31:0]        jobs_done;
        logic [47:0]        waiting_total;
        logic [47:0]        turnaround_total;
        logic [47:0]        response_total;
    } t_out_word;

    // one job as held in a core slot or a queue slot
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] length;
        logic [30:0] arrival;
        logic [15:0] remaining;
        logic [30:0] last;
        logic [30:0] response;
        logic        started;
    } t_job;

    function automatic logic goes_before(input logic [2:0] scheme, input t_job a,
                                         input t_job b);
        logic res;
        res = 1'b0;
        if (scheme == SCH_SJF || scheme == SCH_PSJF) begin
            res = a.remaining < b.remaining;
        end else if (scheme == SCH_PRI || scheme == SCH_PPRI) begin
            res = (a.prio < b.prio) || (a.prio == b.prio && a.arrival < b.arrival);
        end
        return res;
    endfunction

    // saturating charge of elapsed time; time running backwards charges nothing
    function automatic t_job charge(input t_job j, input logic [30:0] now);
        t_job        r;
        logic [30:0] e;
        r = j;
        e = now - j.last;
        if (now >= j.last) begin
            r.remaining = (e >= 31'(j.remaining)) ? 16'd0 : j.remaining - e[15:0];
        end
        r.last = now;
        return r;
    endfunction

    function automatic t_job mark_started(input t_job j, input logic [30:0] now);
        t_job r;
        r = j;
        if (!j.started) begin
            r.response = now - j.arrival;
            r.started  = 1'b1;
        end
        return r;
    endfunction

    function automatic t_job unstart(input t_job j, input logic [30:0] now);
        t_job r;
        r = j;
        if (j.started && j.response == (now - j.arrival)) begin
            r.started = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/multicore_job_scheduler.sv]
// Top level of the multicore job scheduler: config registers, handshakes and output word.
//
// Input channel: i_in_valid / o_in_stall carry one command word (new job, job finished,
// quantum expired). A word is taken when valid is high and stall is low; stall is high
// while a command is being worked on.
// Output channel: o_out_valid / i_out_stall carry one result word per command: the core
// or job selected (-1 for no change), the overflow flag and the running totals.
// Config: i_cfg_we with i_cfg_index (0 scheme, 1 active cores) and i_cfg_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Steps: a new job is placed on a free core if there is one. A PSJF/PPRI scan visits
// each active core in turn and then decides. A sorted insert finds the slot and shifts
// the entries behind it; a quantum requeue finds the slot and shifts the entries ahead
// of it; a take from the front shifts the queue once. The queue memory has a single
// read and write port and is walked one entry at a time; one command is worked at a time.
// The output register lets the next command be taken while a result waits; a result that
// finds the register still full and stalled holds the block until it drains.
// Reset (synchronous, active low) idles all cores, empties the queue and clears totals.
module multicore_job_scheduler #(
    parameter int CORES       = mjs_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mjs_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mjs_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data
);
    logic [2:0]         r_scheme;
    logic [4:0]         r_active;
    logic               r_out_valid;
    mjs_pkg::t_out_word r_out_word;

    logic               eng_busy;
    logic               eng_done;
    logic               res_ready;
    mjs_pkg::t_out_word eng_res;

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= mjs_pkg::SCHEME_RST;
            r_active <= mjs_pkg::ACTIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mjs_pkg::CFG_SCHEME: r_scheme <= i_cfg_data[2:0];
                mjs_pkg::CFG_CORES:  r_active <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done && res_ready) begin
            r_out_word <= eng_res;
        end
    end

    mjs_engine #(
        .CORES       (CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !eng_busy),
        .i_item      (i_in_word),
        .i_scheme    (r_scheme),
        .i_active    (r_active),
        .i_res_ready (res_ready),
        .o_busy      (eng_busy),
        .o_done      (eng_done),
        .o_res       (eng_res)
    );

    assign o_in_stall  = eng_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[rtl/core/mjs_engine.sv]
// Scheduling engine: core and queue memories with the sequencer that walks them.
module mjs_engine #(
    parameter int CORES       = mjs_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mjs_pkg::t_in_word i_item,
    input  logic [2:0]        i_scheme,
    input  logic [4:0]        i_active,
    input  logic              i_res_ready,
    output logic              o_busy,
    output logic              o_done,
    output mjs_pkg::t_out_word o_res
);
    localparam int CW   = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int NW   = $clog2(CORES + 1);
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_PSCAN = 4'd2;
    localparam logic [3:0] S_PDEC  = 4'd3;
    localparam logic [3:0] S_INS   = 4'd4;
    localparam logic [3:0] S_IFIND = 4'd5;
    localparam logic [3:0] S_ISH   = 4'd6;
    localparam logic [3:0] S_IWR   = 4'd7;
    localparam logic [3:0] S_XRD   = 4'd8;
    localparam logic [3:0] S_XFIND = 4'd9;
    localparam logic [3:0] S_XSH   = 4'd10;
    localparam logic [3:0] S_XWR   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_TAKE  = 4'd13;
    localparam logic [3:0] S_TSH   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    mjs_pkg::t_job r_cmem [CORES];
    mjs_pkg::t_job r_qmem [QUEUE_DEPTH];

    logic [3:0]          r_state;
    mjs_pkg::t_in_word   r_item;
    mjs_pkg::t_job       r_c_rd;
    mjs_pkg::t_job       r_q_rd;
    mjs_pkg::t_job       r_ins;
    mjs_pkg::t_job       r_best;
    mjs_pkg::t_job       r_front;
    logic [CW-1:0]       r_best_idx;
    logic [NW-1:0]       r_cix;
    logic [CNTW-1:0]     r_idx;
    logic [CNTW-1:0]     r_slot;
    logic [CNTW-1:0]     r_cnt;
    logic [CORES-1:0]    r_busy;
    logic signed [16:0]  r_sel;
    logic                r_ovf;
    logic [31:0]         r_jobs;
    logic [47:0]         r_sum_wait;
    logic [47:0]         r_sum_turn;
    logic [47:0]         r_sum_resp;

    logic [NW-1:0]   ncore;
    logic            idle_found;
    logic [CW-1:0]   idle_idx;
    logic            ci_ok;
    logic [CW-1:0]   ci_a;
    logic [30:0]     now;
    mjs_pkg::t_job   new_v;
    mjs_pkg::t_job   new_q;
    mjs_pkg::t_job   c_chg;
    mjs_pkg::t_job   take_v;
    mjs_pkg::t_job   front_v;
    logic            better;
    logic            preempt;
    logic            q_before;
    logic [CNTW-1:0] idx_p1;
    logic [CNTW-1:0] k_slot;
    logic [NW-1:0]   cix_p1;

    assign now    = r_item.now;
    assign ci_a   = CW'(r_item.core_index);
    assign idx_p1 = r_idx + 1'b1;
    assign cix_p1 = r_cix + 1'b1;

    always_comb begin
        if (i_active == 5'd0) begin
            ncore = NW'(1);
        end else if (int'(i_active) > CORES) begin
            ncore = NW'(CORES);
        end else begin
            ncore = NW'(i_active);
        end
    end

    assign ci_ok = int'(r_item.core_index) < int'(ncore);

    // lowest free core among those in use
    always_comb begin
        idle_found = 1'b0;
        idle_idx   = '0;
        for (int i = CORES - 1; i >= 0; i--) begin
            if (i < int'(ncore) && !r_busy[i]) begin
                idle_found = 1'b1;
                idle_idx   = CW'(i);
            end
        end
    end

    always_comb begin
        new_v.id        = r_item.job_id;
        new_v.prio      = r_item.job_priority;
        new_v.length    = r_item.run_length;
        new_v.arrival   = now;
        new_v.remaining = r_item.run_length;
        new_v.last      = now;
        new_v.response  = '0;
        new_v.started   = 1'b1;
        new_q           = new_v;
        new_q.started   = 1'b0;
    end

    assign c_chg = (i_scheme == mjs_pkg::SCH_PSJF) ? mjs_pkg::charge(r_c_rd, now) : r_c_rd;

    always_comb begin
        if (i_scheme == mjs_pkg::SCH_PPRI) begin
            better = (c_chg.prio > r_best.prio) ||
                     (c_chg.prio == r_best.prio && c_chg.arrival > r_best.arrival);
            preempt = r_best.prio > r_item.job_priority;
        end else begin
            better  = c_chg.remaining > r_best.remaining;
            preempt = r_best.remaining > r_item.run_length;
        end
    end

    always_comb begin
        take_v = r_q_rd;
        if (r_item.command == mjs_pkg::CMD_FIN) begin
            take_v.last = now;
        end
        take_v = mjs_pkg::mark_started(take_v, now);
    end

    assign front_v  = (r_idx == '0) ? r_q_rd : r_front;
    assign q_before = mjs_pkg::goes_before(i_scheme, r_ins, r_q_rd);
    assign k_slot   = q_before ? r_idx : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_busy     <= '0;
            r_cnt      <= '0;
            r_jobs     <= '0;
            r_sum_wait <= '0;
            r_sum_turn <= '0;
            r_sum_resp <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_sel   <= mjs_pkg::SEL_NONE;
                        r_ovf   <= 1'b0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_item.command)
                        mjs_pkg::CMD_NEW: begin
                            if (idle_found) begin
                                r_cmem[idle_idx] <= new_v;
                                r_busy[idle_idx] <= 1'b1;
                                r_sel            <= 17'(idle_idx);
                                r_state          <= S_DONE;
                            end else if (i_scheme == mjs_pkg::SCH_PSJF ||
                                         i_scheme == mjs_pkg::SCH_PPRI) begin
                                r_c_rd  <= r_cmem[0];
                                r_cix   <= '0;
                                r_state <= S_PSCAN;
                            end else begin
                                r_ins   <= new_q;
                                r_state <= S_INS;
                            end
                        end
                        mjs_pkg::CMD_FIN: begin
                            if (ci_ok && r_busy[ci_a]) begin
                                r_c_rd  <= r_cmem[ci_a];
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        mjs_pkg::CMD_EXP: begin
                            if (!ci_ok) begin
                                r_state <= S_DONE;
                            end else if (!r_busy[ci_a]) begin
                                if (r_cnt != '0) begin
                                    r_q_rd  <= r_qmem[0];
                                    r_state <= S_TAKE;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_c_rd  <= r_cmem[ci_a];
                                r_state <= S_XRD;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_PSCAN: begin
                    // charge (PSJF) and track the preemption candidate
                    if (i_scheme == mjs_pkg::SCH_PSJF) begin
                        r_cmem[r_cix[CW-1:0]] <= c_chg;
                    end
                    if (r_cix == '0 || (c_chg.arrival != now && better)) begin
                        r_best     <= c_chg;
                        r_best_idx <= r_cix[CW-1:0];
                    end
                    if (cix_p1 == ncore) begin
                        r_state <= S_PDEC;
                    end else begin
                        r_c_rd <= r_cmem[cix_p1[CW-1:0]];
                        r_cix  <= cix_p1;
                    end
                end
                S_PDEC: begin
                    if (preempt) begin
                        r_cmem[r_best_idx] <= new_v;
                        r_sel              <= 17'(r_best_idx);
                        r_ins              <= mjs_pkg::unstart(r_best, now);
                    end else begin
                        r_ins <= new_q;
                    end
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (r_cnt >= CNTW'(QUEUE_DEPTH)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_cnt == '0) begin
                        r_slot  <= '0;
                        r_state <= S_IWR;
                    end else begin
                        r_q_rd  <= r_qmem[0];
                        r_idx   <= '0;
                        r_state <= S_IFIND;
                    end
                end
                S_IFIND: begin
                    if (q_before || idx_p1 == r_cnt) begin
                        r_slot <= k_slot;
                        if (k_slot == r_cnt) begin
                            r_state <= S_IWR;
                        end else begin
                            r_q_rd  <= r_qmem[QW'(r_cnt - 1'b1)];
                            r_idx   <= r_cnt;
                            r_state <= S_ISH;
                        end
                    end else begin
                        r_q_rd <= r_qmem[QW'(idx_p1)];
                        r_idx  <= idx_p1;
                    end
                end
                S_ISH: begin
                    // open a gap at the slot, moving from the back
                    r_qmem[QW'(r_idx)] <= r_q_rd;
                    if (r_idx - 1'b1 == r_slot) begin
                        r_state <= S_IWR;
                    end else begin
                        r_q_rd <= r_qmem[QW'(r_idx - 2'd2)];
                        r_idx  <= r_idx - 1'b1;
                    end
                end
                S_IWR: begin
                    r_qmem[QW'(r_slot)] <= r_ins;
                    r_cnt               <= r_cnt + 1'b1;
                    r_state             <= S_DONE;
                end
                S_XRD: begin
                    r_ins <= r_c_rd;
                    if (r_cnt == '0) begin
                        r_sel   <= 17'(r_c_rd.id);
                        r_state <= S_DONE;
                    end else begin
                        r_q_rd  <= r_qmem[0];
                        r_idx   <= '0;
                        r_state <= S_XFIND;
                    end
                end
                S_XFIND: begin
                    if (r_idx == '0) begin
                        r_front <= r_q_rd;
                    end
                    if (q_before || idx_p1 == r_cnt) begin
                        if (k_slot == '0) begin
                            // would sort to the front: the job stays on its core
                            r_sel   <= 17'(r_ins.id);
                            r_state <= S_DONE;
                        end else begin
                            r_cmem[ci_a] <= mjs_pkg::mark_started(front_v, now);
                            r_sel        <= 17'(front_v.id);
                            r_slot       <= k_slot;
                            r_idx        <= CNTW'(1);
                            if (k_slot == CNTW'(1)) begin
                                r_state <= S_XWR;
                            end else begin
                                r_q_rd  <= r_qmem[QW'(1)];
                                r_state <= S_XSH;
                            end
                        end
                    end else begin
                        r_q_rd <= r_qmem[QW'(idx_p1)];
                        r_idx  <= idx_p1;
                    end
                end
                S_XSH: begin
                    r_qmem[QW'(r_idx - 1'b1)] <= r_q_rd;
                    if (idx_p1 == r_slot) begin
                        r_state <= S_XWR;
                    end else begin
                        r_q_rd <= r_qmem[QW'(idx_p1)];
                        r_idx  <= idx_p1;
                    end
                end
                S_XWR: begin
                    r_qmem[QW'(r_slot - 1'b1)] <= r_ins;
                    r_state                    <= S_DONE;
                end
                S_FIN: begin
                    r_sum_wait <= r_sum_wait + {17'd0, now} - {32'd0, r_c_rd.length}
                                  - {17'd0, r_c_rd.arrival};
                    r_sum_turn <= r_sum_turn + {17'd0, now} - {17'd0, r_c_rd.arrival};
                    r_sum_resp <= r_sum_resp +
                                  (r_c_rd.started ? {17'd0, r_c_rd.response} : 48'd0);
                    r_jobs       <= r_jobs + 1'b1;
                    r_busy[ci_a] <= 1'b0;
                    if (r_cnt != '0) begin
                        r_q_rd  <= r_qmem[0];
                        r_state <= S_TAKE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_TAKE: begin
                    r_cmem[ci_a] <= take_v;
                    r_busy[ci_a] <= 1'b1;
                    r_sel        <= 17'(r_q_rd.id);
                    r_cnt        <= r_cnt - 1'b1;
                    r_idx        <= CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_q_rd  <= r_qmem[QW'(1)];
                        r_state <= S_TSH;
                    end
                end
                S_TSH: begin
                    r_qmem[QW'(r_idx - 1'b1)] <= r_q_rd;
                    if (r_idx == r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_q_rd <= r_qmem[QW'(idx_p1)];
                        r_idx  <= idx_p1;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_res.selection        = r_sel;
        o_res.queue_overflow   = r_ovf;
        o_res.jobs_done        = r_jobs;
        o_res.waiting_total    = r_sum_wait;
        o_res.turnaround_total = r_sum_turn;
        o_res.response_total   = r_sum_resp;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + 1'b1 ||
                            r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count moved by more than one");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("start while busy");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_res_ready) |=> r_state == S_DONE)
        else $error("result dropped before taken");

endmodule

[tb/sched_checker.sv]
// Checker for the job scheduler: predicts each result word and compares it with the block.
module sched_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mjs_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mjs_pkg::t_out_word i_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    output int                 o_pending,
    output int                 o_fails
);

    localparam int NCORE = mjs_pkg::CORES_DEF;
    localparam int QLEN  = mjs_pkg::QUEUE_DEPTH_DEF;

    logic [2:0]         scheme;
    logic [4:0]         active;
    logic               busy [NCORE];
    mjs_pkg::t_job      on_core [NCORE];
    mjs_pkg::t_job      waiting [QLEN];
    int                 qn;
    logic [31:0]        done_cnt;
    logic [47:0]        wait_sum, turn_sum, resp_sum;
    mjs_pkg::t_out_word expected_words[$];
    int                 fails;

    assign o_pending = expected_words.size();
    assign o_fails   = fails;

    function automatic logic ahead(input mjs_pkg::t_job a, input mjs_pkg::t_job b);
        if (scheme == mjs_pkg::SCH_SJF || scheme == mjs_pkg::SCH_PSJF)
            return a.remaining < b.remaining;
        if (scheme == mjs_pkg::SCH_PRI || scheme == mjs_pkg::SCH_PPRI)
            return a.prio < b.prio || (a.prio == b.prio && a.arrival < b.arrival);
        return 1'b0;
    endfunction

    function automatic int slot_for(input mjs_pkg::t_job j);
        int k;
        for (k = 0; k < qn; k++)
            if (ahead(j, waiting[k])) break;
        return k;
    endfunction

    task automatic put_at(input int k, input mjs_pkg::t_job j);
        for (int i = qn; i > k; i--) waiting[i] = waiting[i-1];
        waiting[k] = j;
        qn++;
    endtask

    task automatic pop_front(output mjs_pkg::t_job j);
        j = waiting[0];
        for (int i = 1; i < qn; i++) waiting[i-1] = waiting[i];
        qn--;
    endtask

    task automatic start_clock(input int c, input logic [30:0] now);
        if (!on_core[c].started) begin
            on_core[c].response = now - on_core[c].arrival;
            on_core[c].started  = 1'b1;
        end
    endtask

    task automatic schedule_word(input mjs_pkg::t_in_word w, output mjs_pkg::t_out_word r);
        int            n, idle, best, k;
        logic          preempt;
        mjs_pkg::t_job j, old;
        logic [30:0]   now, e;
        now = w.now;
        n = (active == 0) ? 1 : (active > NCORE ? NCORE : active);
        r.selection = mjs_pkg::SEL_NONE;
        r.queue_overflow = 1'b0;
        if (w.command == mjs_pkg::CMD_NEW) begin
            j = '0;
            j.id = w.job_id; j.length = w.run_length; j.prio = w.job_priority;
            j.arrival = now; j.remaining = w.run_length; j.last = now; j.started = 1'b1;
            idle = n;
            for (int i = 0; i < n; i++)
                if (!busy[i]) begin idle = i; break; end
            if (idle < n) begin
                busy[idle] = 1'b1;
                on_core[idle] = j;
                r.selection = 17'(idle);
            end else begin
                best = 0;
                preempt = 1'b0;
                if (scheme == mjs_pkg::SCH_PPRI) begin
                    for (int i = 0; i < n; i++) begin
                        if (on_core[i].arrival == now) continue;
                        if (on_core[i].prio > on_core[best].prio ||
                            (on_core[i].prio == on_core[best].prio &&
                             on_core[i].arrival > on_core[best].arrival)) best = i;
                    end
                    preempt = on_core[best].prio > j.prio;
                end else if (scheme == mjs_pkg::SCH_PSJF) begin
                    for (int i = 0; i < n; i++) begin
                        // charge time used since the last look, saturating at zero
                        if (now >= on_core[i].last) begin
                            e = now - on_core[i].last;
                            on_core[i].remaining = (e >= 31'(on_core[i].remaining)) ? 16'd0
                                : on_core[i].remaining - e[15:0];
                        end
                        on_core[i].last = now;
                        if (on_core[i].arrival == now) continue;
                        if (on_core[i].remaining > on_core[best].remaining) best = i;
                    end
                    preempt = on_core[best].remaining > j.remaining;
                end
                if (preempt) begin
                    old = on_core[best];
                    if (old.started && old.response == 31'(now - old.arrival))
                        old.started = 1'b0;
                    if (qn >= QLEN) r.queue_overflow = 1'b1;
                    else put_at(slot_for(old), old);
                    on_core[best] = j;
                    r.selection = 17'(best);
                end else begin
                    j.started = 1'b0;
                    if (qn >= QLEN) r.queue_overflow = 1'b1;
                    else put_at(slot_for(j), j);
                end
            end
        end else if (w.command == mjs_pkg::CMD_FIN) begin
            if (w.core_index < n && busy[w.core_index]) begin
                old = on_core[w.core_index];
                wait_sum = 48'(64'(wait_sum) + 64'(now) - 64'(old.length) - 64'(old.arrival));
                turn_sum = 48'(64'(turn_sum) + 64'(now) - 64'(old.arrival));
                resp_sum = resp_sum + (old.started ? 48'(old.response) : 48'd0);
                done_cnt++;
                busy[w.core_index] = 1'b0;
                if (qn > 0) begin
                    pop_front(j);
                    j.last = now;
                    on_core[w.core_index] = j;
                    busy[w.core_index] = 1'b1;
                    start_clock(w.core_index, now);
                    r.selection = 17'(on_core[w.core_index].id);
                end
            end
        end else if (w.command == mjs_pkg::CMD_EXP) begin
            if (w.core_index < n) begin
                if (!busy[w.core_index]) begin
                    if (qn > 0) begin
                        pop_front(j);
                        on_core[w.core_index] = j;
                        busy[w.core_index] = 1'b1;
                        start_clock(w.core_index, now);
                        r.selection = 17'(j.id);
                    end
                end else begin
                    // a job that would sort to the front just keeps its core
                    k = slot_for(on_core[w.core_index]);
                    if (k > 0) begin
                        old = on_core[w.core_index];
                        pop_front(j);
                        on_core[w.core_index] = j;
                        put_at(k - 1, old);
                        start_clock(w.core_index, now);
                    end
                    r.selection = 17'(on_core[w.core_index].id);
                end
            end
        end
        r.jobs_done = done_cnt;
        r.waiting_total = wait_sum;
        r.turnaround_total = turn_sum;
        r.response_total = resp_sum;
    endtask

    always @(posedge i_clk) begin
        mjs_pkg::t_out_word r, x;
        if (!i_rst_n) begin
            scheme = mjs_pkg::SCHEME_RST; active = mjs_pkg::ACTIVE_RST;
            for (int i = 0; i < NCORE; i++) busy[i] = 1'b0;
            qn = 0; done_cnt = '0; wait_sum = '0; turn_sum = '0; resp_sum = '0;
            expected_words.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mjs_pkg::CFG_SCHEME) scheme = i_cfg_data[2:0];
                else active = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                schedule_word(i_in_word, r);
                expected_words.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected, got %h", $time,
                             i_out_word);
                    fails++;
                end else begin
                    x = expected_words.pop_front();
                    if (x.selection !== i_out_word.selection ||
                        x.queue_overflow !== i_out_word.queue_overflow ||
                        x.jobs_done !== i_out_word.jobs_done ||
                        x.waiting_total !== i_out_word.waiting_total ||
                        x.turnaround_total !== i_out_word.turnaround_total ||
                        x.response_total !== i_out_word.response_total) begin
                        $display("%0t: mismatch expected sel %h ovf %b done %h w %h t %h r %h",
                                 $time, x.selection, x.queue_overflow, x.jobs_done,
                                 x.waiting_total, x.turnaround_total, x.response_total);
                        $display("%0t:          actual sel %h ovf %b done %h w %h t %h r %h",
                                 $time, i_out_word.selection, i_out_word.queue_overflow,
                                 i_out_word.jobs_done, i_out_word.waiting_total,
                                 i_out_word.turnaround_total, i_out_word.response_total);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
// Testbench top: drives commands and config into the job scheduler and gives the verdict.
module testbench;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    mjs_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    mjs_pkg::t_out_word out_word;
    logic               cfg_we = 1'b0;
    logic               cfg_index = mjs_pkg::CFG_SCHEME;
    logic [4:0]         cfg_data = '0;
    int                 pending, fails;
    logic [30:0]        tick = '0;
    int                 n_cores = 4;
    int                 idle_cycles = 0;
    logic               hold_done = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    multicore_job_scheduler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sched_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_fails(fails)
    );

    // offer one word and hold it until taken; stall is stable by the falling edge
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] id,
                             input logic [15:0] len, input logic [7:0] prio,
                             input logic [3:0] core);
        logic taken;
        in_valid <= 1'b1;
        in_word  <= '{command: cmd, job_id: id, now: tick, run_length: len,
                      job_priority: prio, core_index: core};
        do begin
            @(negedge i_clk);
            taken = !in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [2:0] sch, input logic [4:0] cores);
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_index <= mjs_pkg::CFG_SCHEME; cfg_data <= {2'b00, sch};
        @(posedge i_clk);
        cfg_index <= mjs_pkg::CFG_CORES; cfg_data <= cores;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cores = cores;
    endtask

    task automatic random_job_mix(input int count);
        int burst, roll;
        logic [15:0] len;
        logic [7:0]  prio;
        logic [1:0]  cmd;
        logic [3:0]  core;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0) begin
                tick = tick + 31'($urandom_range(0, 30));
                roll = $urandom_range(0, 99);
                cmd  = (roll < 55) ? mjs_pkg::CMD_NEW
                                   : (roll < 85 ? mjs_pkg::CMD_FIN : mjs_pkg::CMD_EXP);
                len  = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 40));
                prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3));
                core = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, n_cores - 1));
                send_word(cmd, 16'($urandom), len, prio, core);
                burst--; count--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
        end
    endtask

    // receiver: a randomly chosen stall pattern, with one long hold-off
    // that starts while the sender is offering a word
    initial begin
        int mode, hold_at;
        hold_at = 3000;
        @(posedge i_clk iff i_rst_n);
        for (int c = 0; ; c++) begin
            if (c % 64 == 0) mode = $urandom_range(0, 3);
            if (!hold_done && c >= hold_at && in_valid) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                c += 400;
            end
            out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [2:0] sch_list [11] = '{mjs_pkg::SCH_SJF, mjs_pkg::SCH_PSJF, mjs_pkg::SCH_PPRI,
                                       mjs_pkg::SCH_PRI, mjs_pkg::SCH_RR, mjs_pkg::SCH_PSJF,
                                       mjs_pkg::SCH_PPRI, mjs_pkg::SCH_FCFS, mjs_pkg::SCH_SJF,
                                       mjs_pkg::SCH_PPRI, mjs_pkg::SCH_PSJF};
        int cores_list [11] = '{16, 1, 1, 4, 2, 16, 16, 1, 3, 2, 3};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, idle and inactive cores, full cores, time wrap-back
        send_word(mjs_pkg::CMD_EXP, 16'd0, 16'd1, 8'd0, 4'd1);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd0);
        send_word(mjs_pkg::CMD_NEW, 16'd0, 16'd1, 8'd0, 4'd0);
        send_word(mjs_pkg::CMD_NEW, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);
        tick = 31'd5;
        send_word(mjs_pkg::CMD_NEW, 16'd7, 16'd10, 8'd3, 4'd0);
        send_word(mjs_pkg::CMD_NEW, 16'd8, 16'd20, 8'd3, 4'd0);
        send_word(mjs_pkg::CMD_NEW, 16'd9, 16'd30, 8'd1, 4'd0);
        send_word(mjs_pkg::CMD_NEW, 16'd10, 16'd5, 8'd1, 4'd0);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'hF);
        send_word(mjs_pkg::CMD_EXP, 16'd0, 16'd1, 8'd0, 4'd9);
        tick = 31'd40;
        send_word(mjs_pkg::CMD_EXP, 16'd0, 16'd1, 8'd0, 4'd1);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd0);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd3);
        send_word(mjs_pkg::CMD_EXP, 16'd0, 16'd1, 8'd0, 4'd3);
        tick = 31'h7FFFFFFF;
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd2);
        tick = 31'd60;
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd1);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd0);
        send_word(mjs_pkg::CMD_FIN, 16'd0, 16'd1, 8'd0, 4'd3);

        for (int p = 0; p < 11; p++) begin
            set_regs(sch_list[p], 5'(cores_list[p]));
            random_job_mix(45);
        end

        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fails == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
